>>> hdl/att_pkg.sv
// Shared types, character codes and helpers for the assembly text tokenizer.
package att_pkg;

  localparam int TOKS_PER_BEAT = 3;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

  // token kinds
  localparam logic [3:0] KIND_EOF      = 4'd0;
  localparam logic [3:0] KIND_IDENT    = 4'd1;
  localparam logic [3:0] KIND_NUMBER   = 4'd2;
  localparam logic [3:0] KIND_COMMA    = 4'd3;
  localparam logic [3:0] KIND_DOT      = 4'd4;
  localparam logic [3:0] KIND_COLON    = 4'd5;
  localparam logic [3:0] KIND_LBRACKET = 4'd6;
  localparam logic [3:0] KIND_RBRACKET = 4'd7;
  localparam logic [3:0] KIND_MINUS    = 4'd8;
  localparam logic [3:0] KIND_NEWLINE  = 4'd9;
  localparam logic [3:0] KIND_ERROR    = 4'd10;
  localparam logic [3:0] KIND_NONE     = 4'd15;

  // characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  localparam logic [15:0] POS_MAX   = 16'hFFFF;
  localparam logic [15:0] POS_FIRST = 16'd1;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] char_byte;
    logic       end_of_source;
  } in_beat_t;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [15:0] start_line;
    logic [15:0] start_column;
    logic [15:0] token_length;
    logic        last_of_run;
  } out_beat_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] line;
    logic [15:0] col;
    logic [15:0] len;
  } tok_t;

  // all tokens caused by one input beat
  typedef struct packed {
    logic [1:0]                   count;
    tok_t [TOKS_PER_BEAT-1:0]     tok;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } q_stat_t;

  function automatic logic [15:0] sat_inc(logic [15:0] v);
    return (v == POS_MAX) ? v : v + 16'd1;
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic [3:0] single_kind(logic [7:0] c);
    logic [3:0] k;
    k = KIND_NONE;
    unique case (c)
      CH_LF:    k = KIND_NEWLINE;
      CH_COMMA: k = KIND_COMMA;
      CH_DOT:   k = KIND_DOT;
      CH_COLON: k = KIND_COLON;
      CH_LBRK:  k = KIND_LBRACKET;
      CH_RBRK:  k = KIND_RBRACKET;
      CH_MINUS: k = KIND_MINUS;
      default:  k = KIND_NONE;
    endcase
    return k;
  endfunction

  function automatic bundle_t push_tok(bundle_t b, logic [3:0] k, logic [15:0] ln,
                                       logic [15:0] col, logic [15:0] len);
    bundle_t r;
    r = b;
    if (r.count != 2'(TOKS_PER_BEAT)) begin
      r.tok[r.count] = tok_t'{kind: k, line: ln, col: col, len: len};
      r.count = r.count + 2'd1;
    end
    return r;
  endfunction

endpackage

>>> hdl/att_front.sv
// Scanner front end: takes one byte beat per cycle while the queue is not full, tracks position, builds token groups.
module att_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  att_pkg::in_beat_t in_data,
  input  att_pkg::q_stat_t  q_stat,
  output logic              push_valid,
  output att_pkg::bundle_t  push_bundle
);
  import att_pkg::*;

  typedef enum logic [2:0] {
    M_IDLE, M_IDENT, M_NUMBER, M_COMMENT, M_SLASH, M_ERROR
  } mode_t;

  mode_t       mode, mode_next;
  logic [15:0] cur_line, cur_line_next;
  logic [15:0] cur_col, cur_col_next;
  logic [15:0] tok_line, tok_line_next;
  logic [15:0] tok_col, tok_col_next;
  logic [15:0] tok_len, tok_len_next;
  bundle_t     bnd;
  logic        accept, eff_end;

  assign in_ready    = !q_stat.full;
  assign accept      = in_valid && in_ready;
  assign push_valid  = accept && (bnd.count != 2'd0);
  assign push_bundle = bnd;
  assign eff_end     = in_data.end_of_source
                       || (in_data.has_byte && in_data.char_byte == CH_NUL);

  always_comb begin
    logic [7:0] c;
    logic       take, adv, run_idle, more;
    logic [3:0] sk;
    c             = in_data.char_byte;
    take          = in_data.has_byte && (c != CH_NUL);
    sk            = single_kind(c);
    adv           = 1'b0;
    run_idle      = 1'b0;
    more          = 1'b0;
    bnd           = '0;
    mode_next     = mode;
    cur_line_next = cur_line;
    cur_col_next  = cur_col;
    tok_line_next = tok_line;
    tok_col_next  = tok_col;
    tok_len_next  = tok_len;

    if (take) begin
      unique case (mode)
        M_IDENT, M_NUMBER: begin
          more = (mode == M_IDENT) ? (is_alpha(c) || is_digit(c) || c == CH_UNDER)
                                   : (is_digit(c) || c == CH_DOT);
          if (more) begin
            tok_len_next = sat_inc(tok_len);
            adv = 1'b1;
          end else begin
            bnd = push_tok(bnd, (mode == M_IDENT) ? KIND_IDENT : KIND_NUMBER,
                           tok_line, tok_col, tok_len);
            mode_next = M_IDLE;
            run_idle = 1'b1;
          end
        end
        M_COMMENT: begin
          if (c == CH_LF) begin
            mode_next = M_IDLE;
            run_idle = 1'b1;
          end else begin
            adv = 1'b1;
          end
        end
        M_SLASH: begin
          if (c == CH_SLASH) begin
            mode_next = M_COMMENT;
            adv = 1'b1;
          end else begin
            bnd = push_tok(bnd, KIND_ERROR, tok_line, tok_col, 16'd1);
            mode_next = M_ERROR;
          end
        end
        M_ERROR: ;
        default: run_idle = 1'b1;
      endcase

      if (run_idle) begin
        priority if (c == CH_SPACE || c == CH_TAB || c == CH_CR) begin
          adv = 1'b1;
        end else if (c == CH_SEMI) begin
          mode_next = M_COMMENT;
          adv = 1'b1;
        end else if (c == CH_SLASH || is_alpha(c) || c == CH_UNDER || is_digit(c)) begin
          priority if (c == CH_SLASH) mode_next = M_SLASH;
          else if (is_digit(c))       mode_next = M_NUMBER;
          else                        mode_next = M_IDENT;
          tok_line_next = cur_line;
          tok_col_next  = cur_col;
          tok_len_next  = 16'd1;
          adv = 1'b1;
        end else if (sk != KIND_NONE) begin
          bnd = push_tok(bnd, sk, cur_line, cur_col, 16'd1);
          adv = 1'b1;
        end else begin
          // unknown byte: error at its own position, no advance
          bnd = push_tok(bnd, KIND_ERROR, cur_line, cur_col, 16'd1);
          mode_next = M_ERROR;
        end
      end
    end

    if (adv) begin
      if (c == CH_LF) begin
        cur_line_next = sat_inc(cur_line);
        cur_col_next  = POS_FIRST;
      end else begin
        cur_col_next  = sat_inc(cur_col);
      end
    end

    if (eff_end) begin
      unique case (mode_next)
        M_IDENT, M_NUMBER: begin
          bnd = push_tok(bnd, (mode_next == M_IDENT) ? KIND_IDENT : KIND_NUMBER,
                         tok_line_next, tok_col_next, tok_len_next);
          bnd = push_tok(bnd, KIND_EOF, cur_line_next, cur_col_next, 16'd0);
        end
        M_SLASH: bnd = push_tok(bnd, KIND_ERROR, tok_line_next, tok_col_next, 16'd1);
        M_ERROR: ;
        default: bnd = push_tok(bnd, KIND_EOF, cur_line_next, cur_col_next, 16'd0);
      endcase
      mode_next     = M_IDLE;
      cur_line_next = POS_FIRST;
      cur_col_next  = POS_FIRST;
      tok_line_next = POS_FIRST;
      tok_col_next  = POS_FIRST;
      tok_len_next  = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= M_IDLE;
      cur_line <= POS_FIRST;
      cur_col  <= POS_FIRST;
      tok_line <= POS_FIRST;
      tok_col  <= POS_FIRST;
      tok_len  <= 16'd0;
    end else if (accept) begin
      mode     <= mode_next;
      cur_line <= cur_line_next;
      cur_col  <= cur_col_next;
      tok_line <= tok_line_next;
      tok_col  <= tok_col_next;
      tok_len  <= tok_len_next;
    end
  end

  // end of source always returns the scanner to the top of a fresh source
  a_end_resets: assert property (@(posedge clk) disable iff (rst)
    accept && eff_end |=> mode == M_IDLE && cur_line == POS_FIRST && cur_col == POS_FIRST)
    else $error("scanner not reset after end of source");

  a_pos_nonzero: assert property (@(posedge clk) disable iff (rst)
    cur_line != 16'd0 && cur_col != 16'd0)
    else $error("position counter reached zero");

endmodule

>>> hdl/att_queue.sv
// Short queue of token groups between scanner and token serializer.
module att_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  input  att_pkg::bundle_t push_bundle,
  input  logic             pop,
  output att_pkg::bundle_t head,
  output att_pkg::q_stat_t stat
);
  import att_pkg::*;

  bundle_t           q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_pop;

  assign stat.full     = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign stat.nonempty = (count != '0);
  assign head          = q[rd_ptr];
  assign do_pop        = pop && stat.nonempty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_valid) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)     rd_ptr <= rd_ptr + 1'b1;
      if (push_valid && !do_pop)      count <= count + 1'b1;
      else if (!push_valid && do_pop) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push_valid) q[wr_ptr] <= push_bundle;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push_valid |-> !stat.full)
    else $error("push into full queue");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    push_valid && !do_pop |=> count == $past(count) + 1'b1)
    else $error("queue count lost a push");

endmodule

>>> hdl/att_back.sv
// Token serializer: unpacks one token group at a time onto the result channel.
module att_back (
  input  logic               clk,
  input  logic               rst,
  input  att_pkg::q_stat_t   q_stat,
  input  att_pkg::bundle_t   head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output att_pkg::out_beat_t out_data
);
  import att_pkg::*;

  bundle_t    cur;
  logic [1:0] idx;
  logic       busy, last_tok, load;
  tok_t       t;

  assign last_tok  = (idx == cur.count - 2'd1);
  assign pop       = q_stat.nonempty && (!busy || (out_ready && last_tok));
  assign load      = pop;
  assign t         = cur.tok[idx];
  assign out_valid = busy;
  assign out_data  = out_beat_t'{token_kind: t.kind, start_line: t.line,
                                 start_column: t.col, token_length: t.len,
                                 last_of_run: last_tok};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (busy && out_ready && !last_tok) begin
      idx <= idx + 2'd1;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (busy && out_ready) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) cur <= head;
  end

  a_group_nonempty: assert property (@(posedge clk) disable iff (rst)
    busy |-> cur.count != 2'd0 && idx < cur.count)
    else $error("serializer index outside its group");

  a_mid_group_stays: assert property (@(posedge clk) disable iff (rst)
    busy && out_ready && !last_tok |=> busy && idx == $past(idx) + 2'd1)
    else $error("group cut short");

endmodule

>>> hdl/assembly_text_tokenizer.sv
// Assembly text tokenizer: scanner front, group queue and token serializer.
// A byte's first token passes the group queue and then the serializer register before
// it is valid. Input takes one byte beat per cycle while the queue is not full; one
// token leaves per cycle while out_ready is high, so a byte that yields two or three
// tokens holds the output for each, absorbed by a four-group queue between scanner and serializer.
// Reset (rst, synchronous): scanner back to line 1 column 1, queue and output empty.
module assembly_text_tokenizer (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  att_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output att_pkg::out_beat_t out_data
);
  import att_pkg::*;

  q_stat_t q_stat;
  bundle_t push_bundle, head;
  logic    push_valid, pop;

  att_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .q_stat      (q_stat),
    .push_valid  (push_valid),
    .push_bundle (push_bundle)
  );

  att_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .push_valid  (push_valid),
    .push_bundle (push_bundle),
    .pop         (pop),
    .head        (head),
    .stat        (q_stat)
  );

  att_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> verif/tb_assembly_text_tokenizer.sv
// Self-checking testbench for the assembly text tokenizer.
module tb_assembly_text_tokenizer;
  timeunit 1ns;
  timeprecision 1ps;
  import att_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 1_000_000;
  localparam int unsigned RANDOM_ITEMS = 230;

  localparam logic [7:0] CH_DIGIT0 = 8'h30;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_LOWER_A = 8'h61;

  typedef enum logic [2:0] {
    SC_IDLE, SC_IDENT, SC_NUMBER, SC_COMMENT, SC_SLASH, SC_DISCARD
  } scan_mode_t;

  typedef enum {END_BY_ZERO, END_BY_FLAG, END_BY_MARK} src_end_t;

  class token_checker;
    scan_mode_t  mode;
    logic [15:0] line, col, tok_line, tok_col, tok_len;
    out_beat_t   beat_tokens[$];
    out_beat_t   pending_tokens[$];
    int          mismatches;
    int          matched;
    int          beats_taken;

    function new();
      restart();
    endfunction

    function void restart();
      mode     = SC_IDLE;
      line     = POS_FIRST;
      col      = POS_FIRST;
      tok_line = POS_FIRST;
      tok_col  = POS_FIRST;
      tok_len  = '0;
    endfunction

    function logic [15:0] bump(logic [15:0] v);
      return (v == POS_MAX) ? v : v + 16'd1;
    endfunction

    function bit is_letter(logic [7:0] c);
      return (c >= CH_LOWER_A && c <= CH_LOWER_A + 8'd25) ||
             (c >= CH_UPPER_A && c <= CH_UPPER_A + 8'd25);
    endfunction

    function bit is_numeral(logic [7:0] c);
      return c >= CH_DIGIT0 && c <= CH_DIGIT0 + 8'd9;
    endfunction

    function void add_token(logic [3:0] kind, logic [15:0] ln, logic [15:0] cl,
                            logic [15:0] len);
      out_beat_t t;
      t.token_kind   = kind;
      t.start_line   = ln;
      t.start_column = cl;
      t.token_length = len;
      t.last_of_run  = 1'b0;
      if (beat_tokens.size() < TOKS_PER_BEAT) beat_tokens.push_back(t);
    endfunction

    function void move_past(logic [7:0] c);
      if (c == CH_LF) begin
        line = bump(line);
        col  = POS_FIRST;
      end else begin
        col = bump(col);
      end
    endfunction

    function void open_token(scan_mode_t m);
      mode     = m;
      tok_line = line;
      tok_col  = col;
      tok_len  = 16'd1;
    endfunction

    function void lex_idle(logic [7:0] c);
      logic [3:0] kind;
      kind = KIND_NONE;
      case (c)
        CH_SPACE, CH_TAB, CH_CR: begin
          move_past(c);
          return;
        end
        CH_SEMI: begin
          mode = SC_COMMENT;
          move_past(c);
          return;
        end
        CH_SLASH: begin
          open_token(SC_SLASH);
          move_past(c);
          return;
        end
        CH_LF:    kind = KIND_NEWLINE;
        CH_COMMA: kind = KIND_COMMA;
        CH_DOT:   kind = KIND_DOT;
        CH_COLON: kind = KIND_COLON;
        CH_LBRK:  kind = KIND_LBRACKET;
        CH_RBRK:  kind = KIND_RBRACKET;
        CH_MINUS: kind = KIND_MINUS;
        default:  kind = KIND_NONE;
      endcase
      if (kind != KIND_NONE) begin
        add_token(kind, line, col, 16'd1);
        move_past(c);
      end else if (is_letter(c) || c == CH_UNDER) begin
        open_token(SC_IDENT);
        move_past(c);
      end else if (is_numeral(c)) begin
        open_token(SC_NUMBER);
        move_past(c);
      end else begin
        // bad byte: position does not move
        add_token(KIND_ERROR, line, col, 16'd1);
        mode = SC_DISCARD;
      end
    endfunction

    function void lex_byte(logic [7:0] c);
      bit more;
      case (mode)
        SC_IDENT, SC_NUMBER: begin
          more = (mode == SC_IDENT) ? (is_letter(c) || is_numeral(c) || c == CH_UNDER)
                                    : (is_numeral(c) || c == CH_DOT);
          if (more) begin
            tok_len = bump(tok_len);
            move_past(c);
          end else begin
            add_token((mode == SC_IDENT) ? KIND_IDENT : KIND_NUMBER,
                      tok_line, tok_col, tok_len);
            mode = SC_IDLE;
            lex_idle(c);
          end
        end
        SC_COMMENT: begin
          if (c == CH_LF) begin
            mode = SC_IDLE;
            lex_idle(c);
          end else begin
            move_past(c);
          end
        end
        SC_SLASH: begin
          if (c == CH_SLASH) begin
            mode = SC_COMMENT;
            move_past(c);
          end else begin
            add_token(KIND_ERROR, tok_line, tok_col, 16'd1);
            mode = SC_DISCARD;
          end
        end
        SC_DISCARD: ;
        default: lex_idle(c);
      endcase
    endfunction

    function void close_source();
      case (mode)
        SC_IDENT, SC_NUMBER: begin
          add_token((mode == SC_IDENT) ? KIND_IDENT : KIND_NUMBER,
                    tok_line, tok_col, tok_len);
          add_token(KIND_EOF, line, col, 16'd0);
        end
        SC_SLASH:   add_token(KIND_ERROR, tok_line, tok_col, 16'd1);
        SC_DISCARD: ;
        default:    add_token(KIND_EOF, line, col, 16'd0);
      endcase
      restart();
    endfunction

    // accepted input beat: predict the tokens it causes
    function void take_beat(in_beat_t b);
      bit ends;
      beat_tokens.delete();
      ends = b.end_of_source;
      if (b.has_byte && b.char_byte == CH_NUL) ends = 1'b1;
      else if (b.has_byte) lex_byte(b.char_byte);
      if (ends) close_source();
      if (beat_tokens.size() > 0) beat_tokens[$].last_of_run = 1'b1;
      foreach (beat_tokens[i]) pending_tokens.push_back(beat_tokens[i]);
      beats_taken++;
    endfunction

    task report(string what);
      // keep the log short when things go badly wrong
      if (mismatches < 40) $display("mismatch at token %0d: %s", matched, what);
      mismatches++;
    endtask

    task check_token(out_beat_t got);
      out_beat_t want;
      if (pending_tokens.size() == 0) begin
        report($sformatf("unexpected token kind %0d line %0d col %0d len %0d",
                         got.token_kind, got.start_line, got.start_column,
                         got.token_length));
        return;
      end
      want = pending_tokens.pop_front();
      if (got.token_kind !== want.token_kind)
        report($sformatf("kind %0d, want %0d", got.token_kind, want.token_kind));
      if (got.start_line !== want.start_line)
        report($sformatf("line %0d, want %0d", got.start_line, want.start_line));
      if (got.start_column !== want.start_column)
        report($sformatf("column %0d, want %0d", got.start_column, want.start_column));
      if (got.token_length !== want.token_length)
        report($sformatf("length %0d, want %0d", got.token_length, want.token_length));
      if (got.last_of_run !== want.last_of_run)
        report($sformatf("last %0b, want %0b", got.last_of_run, want.last_of_run));
      matched++;
    endtask
  endclass

  logic      clk;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;

  token_checker chk = new();
  in_beat_t     src_q[$];
  int unsigned  items_sent = 0;
  int unsigned  sources_sent = 0;
  int           burst_left = 0;
  int unsigned  cycle_count = 0;

  assembly_text_tokenizer dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst) begin
      if (in_valid && in_ready) chk.take_beat(in_data);
      if (out_valid && out_ready) chk.check_token(out_data);
    end
  end

  initial begin
    wait (cycle_count >= LIMIT_CYCLES);
    $display("timeout after %0d cycles, %0d tokens still due", cycle_count,
             chk.pending_tokens.size());
    $display("RESULT: ERROR");
    $finish;
  end

  // receiver: ready pattern changes after each random span
  initial begin
    int pat;
    int span;
    int tick;
    tick = 0;
    @(posedge clk);
    forever begin
      pat  = $urandom_range(0, 3);
      span = $urandom_range(16, 96);
      repeat (span) begin
        case (pat)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 3) != 0);
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= (tick % 3 == 0);
        endcase
        tick++;
        @(posedge clk);
      end
    end
  end

  task automatic send_beat(in_beat_t b);
    logic [$bits(in_beat_t)-1:0] junk;
    if (burst_left == 0) begin
      junk = $urandom;
      in_valid <= 1'b0;
      in_data  <= junk;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 6);
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (b.has_byte || b.end_of_source) items_sent++;
  endtask

  task automatic send_queued();
    foreach (src_q[i]) send_beat(src_q[i]);
    src_q.delete();
    sources_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    // let the monitor note the last accepted beat first
    @(posedge clk);
    while (chk.pending_tokens.size() != 0) @(posedge clk);
  endtask

  function automatic void add_byte(logic [7:0] c);
    src_q.push_back(in_beat_t'{1'b1, c, 1'b0});
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic void add_empty();
    src_q.push_back(in_beat_t'{1'b0, 8'($urandom), 1'b0});
  endfunction

  task automatic run_source(src_end_t how);
    if (how == END_BY_FLAG && src_q.size() > 0 && src_q[$].has_byte)
      src_q[$].end_of_source = 1'b1;
    else if (how == END_BY_ZERO)
      src_q.push_back(in_beat_t'{1'b1, CH_NUL, 1'($urandom)});
    else
      src_q.push_back(in_beat_t'{1'b0, 8'($urandom), 1'b1});
    send_queued();
  endtask

  function automatic logic [7:0] ident_char(bit first);
    int r;
    r = $urandom_range(0, first ? 52 : 62);
    if (r < 26) return CH_LOWER_A + 8'(r);
    if (r < 52) return CH_UPPER_A + 8'(r - 26);
    if (r == 52) return CH_UNDER;
    return CH_DIGIT0 + 8'(r - 53);
  endfunction

  function automatic logic [7:0] punct_char();
    case ($urandom_range(0, 5))
      0:       return CH_COMMA;
      1:       return CH_DOT;
      2:       return CH_COLON;
      3:       return CH_LBRK;
      4:       return CH_RBRK;
      default: return CH_MINUS;
    endcase
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 2))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      default: return CH_CR;
    endcase
  endfunction

  function automatic void add_comment();
    logic [7:0] c;
    if ($urandom_range(0, 1) == 0) add_byte(CH_SEMI);
    else begin
      add_byte(CH_SLASH);
      add_byte(CH_SLASH);
    end
    repeat ($urandom_range(0, 8)) begin
      c = 8'($urandom_range(1, 255));
      add_byte((c == CH_LF) ? CH_SPACE : c);
    end
  endfunction

  // mostly well-formed lines; a noisy source may carry bad bytes or lone slashes
  task automatic gen_source();
    bit noisy;
    int n_lines;
    int n_elems;
    noisy   = ($urandom_range(0, 4) == 0);
    n_lines = $urandom_range(1, 3);
    for (int ln = 0; ln < n_lines; ln++) begin
      n_elems = $urandom_range(0, 5);
      for (int e = 0; e < n_elems; e++) begin
        if ($urandom_range(0, 11) == 0) add_empty();
        case ($urandom_range(0, noisy ? 9 : 8))
          0, 1, 2, 3: begin
            add_byte(ident_char(1'b1));
            repeat ($urandom_range(0, 9)) add_byte(ident_char(1'b0));
          end
          4, 5: begin
            add_byte(CH_DIGIT0 + 8'($urandom_range(0, 9)));
            repeat ($urandom_range(0, 5))
              add_byte(($urandom_range(0, 3) == 0) ? CH_DOT
                                                   : CH_DIGIT0 + 8'($urandom_range(0, 9)));
          end
          6, 7: add_byte(punct_char());
          8: repeat ($urandom_range(1, 3)) add_byte(blank_char());
          default: add_byte(($urandom_range(0, 2) == 0) ? CH_SLASH
                                                        : 8'($urandom_range(1, 255)));
        endcase
        if ($urandom_range(0, 1) == 0) add_byte(blank_char());
      end
      if ($urandom_range(0, 2) == 0) add_comment();
      // last line sometimes left open so a token is pending at the end
      if (ln < n_lines - 1 || $urandom_range(0, 2) != 0) add_byte(CH_LF);
    end
    case ($urandom_range(0, 2))
      0:       run_source(END_BY_ZERO);
      1:       run_source(END_BY_FLAG);
      default: run_source(END_BY_MARK);
    endcase
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: every kind, comment forms, slash cases, bad byte, all endings
    add_text("_Z9,.:[]-\n");
    run_source(END_BY_MARK);
    add_text("0.9;");
    add_byte(CH_CR);
    add_byte(CH_LF);
    run_source(END_BY_ZERO);
    add_text("q/");
    run_source(END_BY_FLAG);
    add_text("//");
    run_source(END_BY_FLAG);
    add_text("/w");
    run_source(END_BY_FLAG);
    add_byte(8'hFF);
    add_text("b");
    run_source(END_BY_FLAG);
    add_text("x\n");
    run_source(END_BY_FLAG);
    add_empty();
    run_source(END_BY_MARK);
    wait_drained();

    while (items_sent < RANDOM_ITEMS / 2) gen_source();
    wait_drained();

    while (items_sent < RANDOM_ITEMS) gen_source();
    wait_drained();
    repeat (12) @(posedge clk);

    $display("covered %0d sources, %0d beats, %0d tokens checked: all kinds, comments,",
             sources_sent, chk.beats_taken, chk.matched);
    $display("  slash and bad-byte errors, empty beats and every way a source can end");
    if (chk.mismatches == 0 && chk.pending_tokens.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
